### src/cstd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstd_pkg
// Types, constants and helpers for the concentric square-to-disk mapper.
// ----------------------------------------------------------------------------
package cstd_pkg;

  localparam int COORD_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_COUNT   = 25;
  localparam int CSTEPS       = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;

  localparam int WFRAC = 30;
  localparam logic [31:0] KINV_Q32 = 32'h9B74EDA8;
  localparam int OUT_MAX = 32767;

  // centred coordinate, radius and divider widths
  localparam int A_W   = COORD_BITS + 2;
  localparam int R_W   = COORD_BITS + 1;
  localparam int REM_W = R_W + 1;
  localparam int DIV_BITS    = 30;
  localparam int DIV_PER_STG = 3;
  localparam int DIV_STG     = (DIV_BITS + DIV_PER_STG - 1) / DIV_PER_STG;

  // rotator widths
  localparam int W   = 34;
  localparam int Z_W = 33;
  localparam int ROT_PER_STG = 2;
  localparam int ROT_STG     = (CSTEPS + ROT_PER_STG - 1) / ROT_PER_STG;
  localparam int KSH = 32 - WFRAC + COORD_BITS;

  typedef struct packed {
    logic [15:0] seed_x;
    logic [15:0] seed_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] disk_x;
    logic signed [15:0] disk_y;
  } out_item_t;

  // per-item sideband carried alongside the divider
  typedef struct packed {
    logic [R_W-1:0] r;
    logic [1:0]     k;    // region, base angle k/4 turn
    logic           sub;  // quotient enters the angle negated
  } side_t;

  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051D;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2E;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      24: v = 32'h00000028;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // round to Q1.15 and clamp
  function automatic logic signed [15:0] finish(input logic signed [W-1:0] v);
    logic signed [W-1:0] o;
    o = (v + (W'(1) <<< (WFRAC - 16))) >>> (WFRAC - 15);
    if (o > W'(OUT_MAX)) begin
      o = W'(OUT_MAX);
    end else if (o < -W'(OUT_MAX)) begin
      o = -W'(OUT_MAX);
    end
    return o[15:0];
  endfunction

endpackage

### src/cstd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstd_div
// Pipelined restoring divider: q = (n << 29) / d for n <= d, d != 0.
// ----------------------------------------------------------------------------
module cstd_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [cstd_pkg::R_W-1:0]          n,
  input  logic [cstd_pkg::R_W-1:0]          d,
  input  cstd_pkg::side_t                   side_in,
  output logic                              out_valid,
  output logic [cstd_pkg::DIV_BITS-1:0]     q,
  output cstd_pkg::side_t                   side_out
);
  import cstd_pkg::*;

  // divide n << 30 by 2d: every quotient bit is then a uniform shift-compare step
  logic [REM_W-1:0]    rem_q   [DIV_STG+1];
  logic [R_W-1:0]      d_q     [DIV_STG+1];
  logic [DIV_BITS-1:0] quo_q   [DIV_STG+1];
  side_t               side_q  [DIV_STG+1];
  logic                v_q     [DIV_STG+1];

  assign rem_q[0]  = REM_W'(n);
  assign d_q[0]    = d;
  assign quo_q[0]  = '0;
  assign side_q[0] = side_in;
  assign v_q[0]    = in_valid;

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    logic [REM_W-1:0]    rem_nxt, rem_r;
    logic [DIV_BITS-1:0] quo_nxt, quo_r;
    logic [R_W-1:0]      d_r;
    side_t               side_r;
    logic                v_r;

    always_comb begin
      logic [REM_W:0] t;
      logic [REM_W:0] dd;
      rem_nxt = rem_q[s];
      quo_nxt = quo_q[s];
      dd      = {1'b0, d_q[s], 1'b0};
      for (int j = 0; j < DIV_PER_STG; j++) begin
        if (s * DIV_PER_STG + j < DIV_BITS) begin
          t = {rem_nxt, 1'b0};
          if (t >= dd) begin
            rem_nxt = REM_W'(t - dd);
            quo_nxt = {quo_nxt[DIV_BITS-2:0], 1'b1};
          end else begin
            rem_nxt = t[REM_W-1:0];
            quo_nxt = {quo_nxt[DIV_BITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_q[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        d_r    <= d_q[s];
        side_r <= side_q[s];
      end
    end

    assign rem_q[s+1]  = rem_r;
    assign quo_q[s+1]  = quo_r;
    assign d_q[s+1]    = d_r;
    assign side_q[s+1] = side_r;
    assign v_q[s+1]    = v_r;
  end

  assign out_valid = v_q[DIV_STG];
  assign q         = quo_q[DIV_STG];
  assign side_out  = side_q[DIV_STG];

endmodule

### src/cstd_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstd_rot
// Angle assembly, 1/K prescale and pipelined rotation CORDIC in turns.
// ----------------------------------------------------------------------------
module cstd_rot (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [cstd_pkg::DIV_BITS-1:0]     q,
  input  cstd_pkg::side_t                   side_in,
  output logic                              out_valid,
  output logic signed [cstd_pkg::W-1:0]     x_out,
  output logic signed [cstd_pkg::W-1:0]     y_out,
  output logic [1:0]                        quad_out
);
  import cstd_pkg::*;

  localparam int PROD_W = R_W + 32;

  // set-up stage
  logic [31:0]             ang, qq, shifted;
  logic [PROD_W-1:0]       prod;
  logic signed [W-1:0]     x0_nxt;
  logic signed [Z_W-1:0]   z0_nxt;
  logic signed [W-1:0]     x0_r;
  logic signed [Z_W-1:0]   z0_r;
  logic [1:0]              quad0_r;
  logic                    v0_r;

  always_comb begin
    qq      = 32'(q);
    ang     = {side_in.k, 30'b0} + (side_in.sub ? (32'd0 - qq) : qq);
    shifted = ang + 32'h20000000;
    prod    = PROD_W'(side_in.r) * PROD_W'(KINV_Q32);
    x0_nxt  = W'(prod >> KSH);
    z0_nxt  = $signed(Z_W'(shifted[29:0])) - $signed(Z_W'(32'h20000000));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r    <= x0_nxt;
      z0_r    <= z0_nxt;
      quad0_r <= shifted[31:30];
    end
  end

  logic signed [W-1:0]   x_q    [ROT_STG+1];
  logic signed [W-1:0]   y_q    [ROT_STG+1];
  logic signed [Z_W-1:0] z_q    [ROT_STG+1];
  logic [1:0]            quad_q [ROT_STG+1];
  logic                  v_q    [ROT_STG+1];

  assign x_q[0]    = x0_r;
  assign y_q[0]    = '0;
  assign z_q[0]    = z0_r;
  assign quad_q[0] = quad0_r;
  assign v_q[0]    = v0_r;

  for (genvar s = 0; s < ROT_STG; s++) begin : g_stg
    logic signed [W-1:0]   x_nxt, y_nxt, x_r, y_r;
    logic signed [Z_W-1:0] z_nxt, z_r;
    logic [1:0]            quad_r;
    logic                  v_r;

    always_comb begin
      logic signed [W-1:0]   dx, dy;
      logic signed [Z_W-1:0] at;
      x_nxt = x_q[s];
      y_nxt = y_q[s];
      z_nxt = z_q[s];
      for (int j = 0; j < ROT_PER_STG; j++) begin
        if (s * ROT_PER_STG + j < CSTEPS) begin
          dx = y_nxt >>> (s * ROT_PER_STG + j);
          dy = x_nxt >>> (s * ROT_PER_STG + j);
          at = $signed(Z_W'(atan_turns(s * ROT_PER_STG + j)));
          if (!z_nxt[Z_W-1]) begin
            x_nxt = x_nxt - dx;
            y_nxt = y_nxt + dy;
            z_nxt = z_nxt - at;
          end else begin
            x_nxt = x_nxt + dx;
            y_nxt = y_nxt - dy;
            z_nxt = z_nxt + at;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_q[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        z_r    <= z_nxt;
        quad_r <= quad_q[s];
      end
    end

    assign x_q[s+1]    = x_r;
    assign y_q[s+1]    = y_r;
    assign z_q[s+1]    = z_r;
    assign quad_q[s+1] = quad_r;
    assign v_q[s+1]    = v_r;
  end

  assign out_valid = v_q[ROT_STG];
  assign x_out     = x_q[ROT_STG];
  assign y_out     = y_q[ROT_STG];
  assign quad_out  = quad_q[ROT_STG];

endmodule

### src/concentric_square_to_disk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// concentric_square_to_disk
// Area-preserving concentric map of a unit-square sample onto the unit disk.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_item carry (seed_x, seed_y), unsigned Q0.16.
//   out_valid/out_stall/out_item carry (disk_x, disk_y), signed Q1.15,
//   clamped to +-32767. One result per item, in order.
//   Throughput: one item per cycle while the output is not stalled. Stages:
//   region select, divider at three quotient bits a stage, angle/prescale
//   multiply, CORDIC at two micro-rotations a stage, rounding/output.
//   The whole pipeline advances together; it holds when the output item is
//   stalled, and in_stall is raised for exactly those cycles. Nothing is
//   lost or repeated across a stall.
//   Reset (rst_n low, synchronous) empties the pipeline; no valid item survives.
// ----------------------------------------------------------------------------
module concentric_square_to_disk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cstd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output cstd_pkg::out_item_t out_item
);
  import cstd_pkg::*;

  localparam logic signed [A_W-1:0] HALF_S = {2'b01, {COORD_BITS{1'b0}}};

  logic en;
  logic out_valid_r;
  out_item_t out_item_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // region select
  logic signed [A_W-1:0] a, b, num, den;
  logic signed [A_W:0]   sum;
  logic [R_W-1:0]        n_nxt, d_nxt, n_r, d_r;
  side_t                 side_nxt, side_r;
  logic                  flip, centre, v_r;

  always_comb begin
    a   = $signed({1'b0, in_item.seed_x[COORD_BITS-1:0], 1'b0}) - HALF_S;
    b   = $signed({1'b0, in_item.seed_y[COORD_BITS-1:0], 1'b0}) - HALF_S;
    sum = (A_W+1)'(a) + (A_W+1)'(b);
    centre = (a == '0) && (b == '0);
    if (sum > 0) begin
      if (a > b) begin
        num = b; den = a; flip = 1'b0; side_nxt.k = 2'd0;
      end else begin
        num = a; den = b; flip = 1'b1; side_nxt.k = 2'd1;
      end
    end else begin
      if (a < b) begin
        num = b; den = a; flip = 1'b0; side_nxt.k = 2'd2;
      end else begin
        num = a; den = b; flip = 1'b1; side_nxt.k = 2'd3;
      end
    end
    n_nxt = R_W'(num[A_W-1] ? -num : num);
    d_nxt = R_W'(den[A_W-1] ? -den : den);
    side_nxt.r   = d_nxt;
    side_nxt.sub = (num[A_W-1] ^ den[A_W-1]) ^ flip;
    // centre: zero radius, zero angle, and keep the divisor non-zero
    if (centre) begin
      side_nxt.k = 2'd0;
      d_nxt      = R_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      d_r    <= d_nxt;
      side_r <= side_nxt;
    end
  end

  logic                div_valid;
  logic [DIV_BITS-1:0] div_q;
  side_t               div_side;

  cstd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_r),
    .n         (n_r),
    .d         (d_r),
    .side_in   (side_r),
    .out_valid (div_valid),
    .q         (div_q),
    .side_out  (div_side)
  );

  logic                rot_valid;
  logic signed [W-1:0] rot_x, rot_y;
  logic [1:0]          rot_quad;

  cstd_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .q         (div_q),
    .side_in   (div_side),
    .out_valid (rot_valid),
    .x_out     (rot_x),
    .y_out     (rot_y),
    .quad_out  (rot_quad)
  );

  // quadrant fold and output rounding
  logic signed [W-1:0] fx, fy;
  out_item_t           out_item_nxt;

  always_comb begin
    case (rot_quad)
      2'd1: begin
        fx = -rot_y; fy = rot_x;
      end
      2'd2: begin
        fx = -rot_x; fy = -rot_y;
      end
      2'd3: begin
        fx = rot_y; fy = -rot_x;
      end
      default: begin
        fx = rot_x; fy = rot_y;
      end
    endcase
    out_item_nxt.disk_x = finish(fx);
    out_item_nxt.disk_y = finish(fy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

### src/cstd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstd_checker
// Port-level checks for the concentric square-to-disk mapper.
// ----------------------------------------------------------------------------
module cstd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input cstd_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input cstd_pkg::out_item_t out_item
);
  import cstd_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  // a stalled input item is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed");

  // input side only backs up when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // results are clamped symmetrically
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.disk_x != -16'sd32768 && out_item.disk_y != -16'sd32768)
    else $error("output outside clamp range");

endmodule

bind concentric_square_to_disk cstd_checker u_cstd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
